// ----- rtl/heightmap_relief_shader_top_assert.svh -----
// Assertion macros for the relief shader top level.
// Used by heightmap_relief_shader_top; depends on nothing else.
`ifndef HEIGHTMAP_RELIEF_SHADER_TOP_ASSERT_SVH
`define HEIGHTMAP_RELIEF_SHADER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRS_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("relief shader check failed");

// The consequent must hold in the cycle after the antecedent.
`define HRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("relief shader check failed");

`endif

// ----- rtl/hrs_pkg.sv -----
// Shared constants, types and helper functions of the relief shader.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hrs_pkg;

    localparam int TILE_SIDE      = 16;
    localparam int HEIGHT_BITS    = 10;
    localparam int POS_BITS       = (TILE_SIDE > 2) ? $clog2(TILE_SIDE) : 1;
    localparam int COLOR_BITS     = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = HEIGHT_BITS;
    localparam int TERM_BITS      = 12;
    localparam int F_BITS         = 14;
    localparam int PROD_BITS      = 22;

    localparam int F_BASE      = 8550;
    localparam int F_MIN       = 4950;
    localparam int F_MAX       = 11250;
    localparam int F_UNIT      = 9000;
    localparam int ROUND_HALF  = F_UNIT / 2;
    localparam int SCALE_SAT   = 255 * F_UNIT;
    // 2^35 / 9000 rounded up; exact for every numerator below SCALE_SAT.
    localparam int RECIP_MUL   = 3817749;
    localparam int RECIP_SHIFT = 35;

    typedef logic signed [HEIGHT_BITS-1:0] height_t;
    typedef logic signed [HEIGHT_BITS:0]   diff_t;
    typedef logic [COLOR_BITS-1:0]         color_t;
    typedef logic [TERM_BITS-1:0]          term_t;
    typedef logic [F_BITS-1:0]             factor_t;
    typedef logic [POS_BITS-1:0]           pos_t;
    typedef logic [CFG_INDEX_BITS-1:0]     cfg_index_t;

    localparam cfg_index_t CFG_LOW_LEVEL  = 2'd0;
    localparam cfg_index_t CFG_HIGH_LEVEL = 2'd1;
    localparam cfg_index_t CFG_BLUE_BOOST = 2'd2;

    localparam height_t LOW_LEVEL_RESET  = height_t'(63);
    localparam height_t HIGH_LEVEL_RESET = height_t'(140);
    localparam color_t  BLUE_BOOST_RESET = color_t'(20);

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

    // Clamped linear term: zero for a negative or zero difference.
    function automatic term_t cap_term(input diff_t d, input logic [6:0] k,
                                       input term_t lim);
        logic [HEIGHT_BITS+6:0] p;
        p = (HEIGHT_BITS+7)'(d[HEIGHT_BITS-1:0]) * (HEIGHT_BITS+7)'(k);
        if (d[HEIGHT_BITS]) begin
            return '0;
        end
        if (p > (HEIGHT_BITS+7)'(lim)) begin
            return lim;
        end
        return p[TERM_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/heightmap_relief_shader_top.sv -----
// Relief shader top level: five-stage pipeline around the height line and shaders.
// Depends on hrs_pkg, hrs_line, hrs_factor, hrs_scale and the assertion header.
//
// Usage: cells arrive in raster order on the s_ channel (valid/ready), one word
// per cell with its base colour and height; s_tile_start marks the first cell
// of a tile. Each accepted word gives exactly one shaded word on the m_ channel
// (valid/ready), in order, with m_tile_end on the last cell of the tile.
// An accepted word moves through the stage registers s1 to s5 in turn, and
// m_valid is the valid flag of stage s5.
// Throughput is one word per cycle while m_ready is high: the line of height cells
// shifts once per accepted word, and every stage advances whenever the stage
// after it is empty or moving.
// When the receiver stalls, the pipeline fills and then drops s_ready; with
// m_ready high, s_ready is always high.
// The configuration port (cfg_we, cfg_index, cfg_data) writes low_level, high_level and
// blue_boost, only while the pipeline is empty: a user rule, not enforced by the block.
// Synchronous reset (aresetn low) empties the pipeline, returns to row 0 and
// column 0 and restores the register defaults of 63, 140 and 20.
`default_nettype none
`include "heightmap_relief_shader_top_assert.svh"

module heightmap_relief_shader_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [hrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [hrs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_tile_start,
    input  wire logic [7:0]                    s_red_in,
    input  wire logic [7:0]                    s_green_in,
    input  wire logic [7:0]                    s_blue_in,
    input  wire logic [7:0]                    s_alpha_in,
    input  wire logic signed [hrs_pkg::HEIGHT_BITS-1:0] s_height,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_red_out,
    output logic [7:0]                         m_green_out,
    output logic [7:0]                         m_blue_out,
    output logic [7:0]                         m_alpha_out,
    output logic                               m_tile_end
);

    hrs_pkg::height_t   low_level_reg, high_level_reg;
    hrs_pkg::color_t    blue_boost_reg;

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    hrs_pkg::stage_en_t en;
    logic               accept;

    hrs_pkg::height_t   north, west;
    logic               last;
    logic               below_low;
    hrs_pkg::factor_t   factor;
    logic               factor_ok;

    hrs_pkg::height_t   h1_reg, n1_reg, w1_reg;
    hrs_pkg::color_t    r1_reg, g1_reg, b1_reg, a1_reg;
    logic               last1_reg;
    hrs_pkg::color_t    r2_reg, g2_reg, b2_reg, a2_reg;
    logic               last2_reg;
    hrs_pkg::color_t    r3_reg, g3_reg, b3_reg, a3_reg;
    logic               last3_reg;
    hrs_pkg::color_t    a4_reg, a5_reg;
    logic               last4_reg, last5_reg;
    logic [hrs_pkg::COLOR_BITS:0] blue_sum;
    hrs_pkg::color_t    b2_next;
    logic               bypass3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_level_reg  <= hrs_pkg::LOW_LEVEL_RESET;
            high_level_reg <= hrs_pkg::HIGH_LEVEL_RESET;
            blue_boost_reg <= hrs_pkg::BLUE_BOOST_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                hrs_pkg::CFG_LOW_LEVEL: begin
                    low_level_reg <= $signed(cfg_data[hrs_pkg::HEIGHT_BITS-1:0]);
                end
                hrs_pkg::CFG_HIGH_LEVEL: begin
                    high_level_reg <= $signed(cfg_data[hrs_pkg::HEIGHT_BITS-1:0]);
                end
                hrs_pkg::CFG_BLUE_BOOST: begin
                    blue_boost_reg <= cfg_data[hrs_pkg::COLOR_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        en.s5   = !v5_reg || m_ready;
        en.s4   = !v4_reg || en.s5;
        en.s3   = !v3_reg || en.s4;
        en.s2   = !v2_reg || en.s3;
        en.s1   = !v1_reg || en.s2;
        s_ready = en.s1;
        accept  = s_valid && en.s1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en.s1) v1_reg <= s_valid;
            if (en.s2) v2_reg <= v1_reg;
            if (en.s3) v3_reg <= v2_reg;
            if (en.s4) v4_reg <= v3_reg;
            if (en.s5) v5_reg <= v4_reg;
        end
    end

    hrs_line u_line (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .tile_start (s_tile_start),
        .height     (s_height),
        .north      (north),
        .west       (west),
        .last       (last)
    );

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            h1_reg    <= s_height;
            n1_reg    <= north;
            w1_reg    <= west;
            r1_reg    <= s_red_in;
            g1_reg    <= s_green_in;
            b1_reg    <= s_blue_in;
            a1_reg    <= s_alpha_in;
            last1_reg <= last;
        end
    end

    hrs_factor u_factor (
        .aclk       (aclk),
        .en         (en),
        .height     (h1_reg),
        .north      (n1_reg),
        .west       (w1_reg),
        .low_level  (low_level_reg),
        .high_level (high_level_reg),
        .below_low  (below_low),
        .factor     (factor)
    );

    // Blue gets its saturating boost below the low level, but only where alpha is not zero.
    always_comb begin
        blue_sum = {1'b0, b1_reg} + {1'b0, blue_boost_reg};
        if (below_low && (a1_reg != '0)) begin
            b2_next = blue_sum[hrs_pkg::COLOR_BITS] ? '1 : blue_sum[hrs_pkg::COLOR_BITS-1:0];
        end else begin
            b2_next = b1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            r2_reg    <= r1_reg;
            g2_reg    <= g1_reg;
            b2_reg    <= b2_next;
            a2_reg    <= a1_reg;
            last2_reg <= last1_reg;
        end
        if (en.s3) begin
            r3_reg    <= r2_reg;
            g3_reg    <= g2_reg;
            b3_reg    <= b2_reg;
            a3_reg    <= a2_reg;
            last3_reg <= last2_reg;
        end
        if (en.s4) begin
            a4_reg    <= a3_reg;
            last4_reg <= last3_reg;
        end
        if (en.s5) begin
            a5_reg    <= a4_reg;
            last5_reg <= last4_reg;
        end
    end

    assign bypass3 = (a3_reg == '0);

    hrs_scale u_scale_red (
        .aclk   (aclk),
        .en     (en),
        .chan   (r3_reg),
        .factor (factor),
        .bypass (bypass3),
        .shaded (m_red_out)
    );

    hrs_scale u_scale_green (
        .aclk   (aclk),
        .en     (en),
        .chan   (g3_reg),
        .factor (factor),
        .bypass (bypass3),
        .shaded (m_green_out)
    );

    hrs_scale u_scale_blue (
        .aclk   (aclk),
        .en     (en),
        .chan   (b3_reg),
        .factor (factor),
        .bypass (bypass3),
        .shaded (m_blue_out)
    );

    assign m_valid     = v5_reg;
    assign m_alpha_out = a5_reg;
    assign m_tile_end  = last5_reg;

    assign factor_ok = (factor >= hrs_pkg::factor_t'(hrs_pkg::F_MIN))
                       && (factor <= hrs_pkg::factor_t'(hrs_pkg::F_MAX));

    `HRS_ASSERT_IMPLIES(a_drained_when_taken, aclk, aresetn, m_ready, s_ready)
    `HRS_ASSERT_IMPLIES(a_factor_in_range, aclk, aresetn, v3_reg, factor_ok)

endmodule

`default_nettype wire

// ----- rtl/hrs_cell.sv -----
// One cell of the height line: holds one stored height and hands it on.
// Depends on hrs_pkg.
`default_nettype none

module hrs_cell (
    input  wire logic             aclk,
    input  wire logic             shift,
    input  wire hrs_pkg::height_t d,
    output hrs_pkg::height_t      q
);

    hrs_pkg::height_t height_reg;

    always_ff @(posedge aclk) begin
        if (shift) begin
            height_reg <= d;
        end
    end

    assign q = height_reg;

endmodule

`default_nettype wire

// ----- rtl/hrs_line.sv -----
// Line of height cells and tile position counters; gives north and west heights.
// Depends on hrs_pkg and hrs_cell.
`default_nettype none

module hrs_line (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic             tile_start,
    input  wire hrs_pkg::height_t height,
    output hrs_pkg::height_t      north,
    output hrs_pkg::height_t      west,
    output logic                  last
);

    localparam hrs_pkg::pos_t POS_LAST = hrs_pkg::pos_t'(hrs_pkg::TILE_SIDE - 1);

    hrs_pkg::height_t chain [hrs_pkg::TILE_SIDE];
    hrs_pkg::pos_t    col_reg, col_next;
    hrs_pkg::pos_t    row_reg, row_next;
    hrs_pkg::pos_t    cur_col, cur_row;

    // A new height enters cell 0; the last cell holds the one from a row ago.
    for (genvar k = 0; k < hrs_pkg::TILE_SIDE; k++) begin : g_cell
        if (k == 0) begin : g_head
            hrs_cell u_cell (
                .aclk  (aclk),
                .shift (accept),
                .d     (height),
                .q     (chain[k])
            );
        end else begin : g_body
            hrs_cell u_cell (
                .aclk  (aclk),
                .shift (accept),
                .d     (chain[k-1]),
                .q     (chain[k])
            );
        end
    end

    always_comb begin
        cur_col  = tile_start ? '0 : col_reg;
        cur_row  = tile_start ? '0 : row_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (cur_col == POS_LAST) begin
                col_next = '0;
                row_next = (cur_row == POS_LAST) ? '0 : cur_row + 1'b1;
            end else begin
                col_next = cur_col + 1'b1;
                row_next = cur_row;
            end
        end
    end

    assign north = (cur_row == '0) ? height : chain[hrs_pkg::TILE_SIDE-1];
    assign west  = (cur_col == '0) ? height : chain[0];
    assign last  = (cur_row == POS_LAST) && (cur_col == POS_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hrs_factor.sv -----
// Brightness factor: clamped height terms, then their sum clamped to range.
// Depends on hrs_pkg.
`default_nettype none

module hrs_factor (
    input  wire logic               aclk,
    input  wire hrs_pkg::stage_en_t en,
    input  wire hrs_pkg::height_t   height,
    input  wire hrs_pkg::height_t   north,
    input  wire hrs_pkg::height_t   west,
    input  wire hrs_pkg::height_t   low_level,
    input  wire hrs_pkg::height_t   high_level,
    output logic                    below_low,
    output hrs_pkg::factor_t        factor
);

    localparam int F_SUM_BITS = hrs_pkg::F_BITS + 1;

    hrs_pkg::height_t lo_nb, hi_nb;
    hrs_pkg::diff_t   d_low, d_high, d_drop, d_occl;
    hrs_pkg::term_t   low_reg, high_reg, drop_reg, occl_reg;
    hrs_pkg::term_t   high_term;
    logic [F_SUM_BITS-1:0] f_sum;
    hrs_pkg::factor_t factor_reg, factor_next;

    always_comb begin
        below_low = height < low_level;
        lo_nb     = (north < west) ? north : west;
        hi_nb     = (north > west) ? north : west;
        d_low     = hrs_pkg::diff_t'(low_level) - hrs_pkg::diff_t'(height);
        d_high    = hrs_pkg::diff_t'(height) - hrs_pkg::diff_t'(high_level);
        d_drop    = hrs_pkg::diff_t'(height) - hrs_pkg::diff_t'(lo_nb);
        d_occl    = hrs_pkg::diff_t'(hi_nb) - hrs_pkg::diff_t'(height);
        high_term = below_low ? '0 : hrs_pkg::cap_term(d_high, 7'd18, 12'd1800);
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            low_reg  <= hrs_pkg::cap_term(d_low, 7'd50, 12'd2250);
            high_reg <= high_term;
            drop_reg <= hrs_pkg::cap_term(d_drop, 7'd90, 12'd1080);
            occl_reg <= hrs_pkg::cap_term(d_occl, 7'd108, 12'd1620);
        end
    end

    always_comb begin
        f_sum = F_SUM_BITS'(hrs_pkg::F_BASE) + F_SUM_BITS'(high_reg)
              + F_SUM_BITS'(drop_reg) - F_SUM_BITS'(low_reg) - F_SUM_BITS'(occl_reg);
        if (f_sum < F_SUM_BITS'(hrs_pkg::F_MIN)) begin
            factor_next = hrs_pkg::factor_t'(hrs_pkg::F_MIN);
        end else if (f_sum > F_SUM_BITS'(hrs_pkg::F_MAX)) begin
            factor_next = hrs_pkg::factor_t'(hrs_pkg::F_MAX);
        end else begin
            factor_next = f_sum[hrs_pkg::F_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            factor_reg <= factor_next;
        end
    end

    assign factor = factor_reg;

endmodule

`default_nettype wire

// ----- rtl/hrs_scale.sv -----
// One colour channel: factor product, rounded division by 9000, saturate or bypass.
// Depends on hrs_pkg.
`default_nettype none

module hrs_scale (
    input  wire logic               aclk,
    input  wire hrs_pkg::stage_en_t en,
    input  wire hrs_pkg::color_t    chan,
    input  wire hrs_pkg::factor_t   factor,
    input  wire logic               bypass,
    output hrs_pkg::color_t         shaded
);

    localparam int PB = hrs_pkg::PROD_BITS;

    logic [PB-1:0]          prod_reg;
    hrs_pkg::color_t        chan_reg;
    logic                   bypass_reg;
    logic [PB-1:0]          num;
    logic [2*PB-1:0]        quot_wide;
    logic                   sat;
    hrs_pkg::color_t        shaded_reg, shaded_next;

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            prod_reg   <= PB'(chan) * PB'(factor);
            chan_reg   <= chan;
            bypass_reg <= bypass;
        end
    end

    always_comb begin
        num       = prod_reg + PB'(hrs_pkg::ROUND_HALF);
        sat       = num >= PB'(hrs_pkg::SCALE_SAT);
        quot_wide = (2*PB)'(num) * (2*PB)'(hrs_pkg::RECIP_MUL);
        if (bypass_reg) begin
            shaded_next = chan_reg;
        end else if (sat) begin
            shaded_next = '1;
        end else begin
            shaded_next = quot_wide[hrs_pkg::RECIP_SHIFT +: hrs_pkg::COLOR_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            shaded_reg <= shaded_next;
        end
    end

    assign shaded = shaded_reg;

endmodule

`default_nettype wire
